// ===== design/assert_macros.svh =====
// Assertion macros for the converter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/slc_pkg.sv =====
// Constants, codes and helper functions for the linear sensor converter.
// No dependencies; imported by the interfaces and all converter modules.
package slc_pkg;

	localparam int MODE_W     = 2;
	localparam int SAMPLE_W   = 8;
	localparam int MASK_W     = 8;
	localparam int VALUE_W    = 64;
	localparam int GAIN_W     = 10;
	localparam int OFFS_W     = 10;
	localparam int EXP_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// 10^8 needs 27 bits; multiplying factors stop at 10^7 (24 bits)
	localparam int POW_W = 27;
	localparam int MUL_W = 24;

	localparam int PROD_W  = 18;   // M * raw
	localparam int P1000_W = 28;   // M * raw * 1000
	localparam int OFFB_W  = 20;   // B * 1000
	localparam int OFF_W   = 44;   // scaled offset
	localparam int ACC_W   = 45;   // sum before result scaling

	localparam logic [MODE_W-1:0] MODE_READING       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UPPER_CRIT    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UPPER_NONCRIT = 2'd2;

	localparam int CRIT_BIT    = 4;
	localparam int NONCRIT_BIT = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_M        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_EXP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_EXP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALVE_READING = 3'd4;

	function automatic logic [POW_W-1:0] pow10_f(input logic [EXP_W-1:0] e);
		logic [POW_W-1:0] p;
		unique case (e)
			4'd0: p = 27'd1;
			4'd1: p = 27'd10;
			4'd2: p = 27'd100;
			4'd3: p = 27'd1000;
			4'd4: p = 27'd10000;
			4'd5: p = 27'd100000;
			4'd6: p = 27'd1000000;
			4'd7: p = 27'd10000000;
			4'd8: p = 27'd100000000;
			default: p = 27'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== design/slc_ifs.sv =====
// Valid/ready channel interfaces of the linear sensor converter.
// Depends on slc_pkg for field widths.
interface slc_req_if;
	import slc_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SAMPLE_W-1:0] sample;
	logic [MASK_W-1:0]   threshold_mask;
	modport source (output valid, mode, sample, threshold_mask, input ready);
	modport sink   (input valid, mode, sample, threshold_mask, output ready);
endinterface

interface slc_rsp_if;
	import slc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      available;
	modport source (output valid, value, available, input ready);
	modport sink   (input valid, value, available, output ready);
endinterface

interface slc_cfg_if;
	import slc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/slc_scale10.sv =====
// Pipelined signed scaling by a power of ten: restoring divide, then multiply.
// Depends on slc_pkg (pow10_f, widths); stalls on a shared enable.
module slc_scale10 #(
	parameter int IW = 20,
	parameter int OW = 44,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [IW-1:0]       x,
	input  logic [SW-1:0]              side_in,
	input  logic [slc_pkg::EXP_W-1:0]  exp_k,
	output logic                       out_valid,
	output logic [OW-1:0]              y,
	output logic [SW-1:0]              side_out
);
	import slc_pkg::*;

	localparam int BPS = 4;
	localparam int NS  = (IW + BPS - 1) / BPS;
	localparam int LO  = IW / 2;
	localparam int HI  = IW - LO;
	localparam int PW  = IW + MUL_W;
	localparam int XW  = (PW > OW) ? PW : OW;

	logic [EXP_W-1:0] div_e, mul_e;
	logic [POW_W-1:0] div_d_q;
	logic [MUL_W-1:0] mul_f_q;

	logic [NS:0]      dv_s;
	logic [POW_W-1:0] rem_s  [0:NS];
	logic [IW-1:0]    qd_s   [0:NS];
	logic             neg_s  [0:NS];
	logic [SW-1:0]    side_s [0:NS];

	logic              mv_s, pv_s, ov_s;
	logic [LO+MUL_W-1:0] pp_lo_s;
	logic [HI+MUL_W-1:0] pp_hi_s;
	logic              mneg_s, pneg_s;
	logic [SW-1:0]     mside_s, pside_s, oside_s;
	logic [OW-1:0]     prod_s, y_s;
	logic [XW-1:0]     full;

	always_comb begin
		if (exp_k[EXP_W-1]) begin
			div_e = EXP_W'(-exp_k);
			mul_e = '0;
		end else begin
			div_e = '0;
			mul_e = exp_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_d_q <= POW_W'(1);
			mul_f_q <= MUL_W'(1);
		end else begin
			div_d_q <= pow10_f(div_e);
			mul_f_q <= MUL_W'(pow10_f(mul_e));
		end
	end

	// magnitude and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s[0]   <= x[IW-1] ? IW'(-x) : IW'(x);
			rem_s[0]  <= '0;
			neg_s[0]  <= x[IW-1];
			side_s[0] <= side_in;
		end
	end

	// restoring division, BPS quotient bits per stage
	for (genvar s = 1; s <= NS; s++) begin : g_div
		logic [POW_W-1:0] rem_n;
		logic [IW-1:0]    qd_n;

		always_comb begin
			logic [POW_W:0] t;
			rem_n = rem_s[s-1];
			qd_n  = qd_s[s-1];
			for (int b = 0; b < BPS; b++) begin
				if ((s - 1) * BPS + b < IW) begin
					t = {rem_n, qd_n[IW-1]};
					if (t >= {1'b0, div_d_q}) begin
						t    = t - {1'b0, div_d_q};
						qd_n = {qd_n[IW-2:0], 1'b1};
					end else begin
						qd_n = {qd_n[IW-2:0], 1'b0};
					end
					rem_n = t[POW_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[s] <= 1'b0;
			end else if (en) begin
				dv_s[s] <= dv_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s]  <= rem_n;
				qd_s[s]   <= qd_n;
				neg_s[s]  <= neg_s[s-1];
				side_s[s] <= side_s[s-1];
			end
		end
	end

	// split multiply, partial-product sum, sign
	assign full = (XW'(pp_hi_s) << LO) + XW'(pp_lo_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s <= 1'b0;
			pv_s <= 1'b0;
			ov_s <= 1'b0;
		end else if (en) begin
			mv_s <= dv_s[NS];
			pv_s <= mv_s;
			ov_s <= pv_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s <= qd_s[NS][LO-1:0] * mul_f_q;
			pp_hi_s <= qd_s[NS][IW-1:LO] * mul_f_q;
			mneg_s  <= neg_s[NS];
			mside_s <= side_s[NS];
			prod_s  <= full[OW-1:0];
			pneg_s  <= mneg_s;
			pside_s <= mside_s;
			y_s     <= pneg_s ? OW'(-prod_s) : prod_s;
			oside_s <= pside_s;
		end
	end

	assign out_valid = ov_s;
	assign y         = y_s;
	assign side_out  = oside_s;

endmodule

// ===== design/sensor_reading_linear_convert.sv =====
// Top level of the linear sensor converter: config registers and pipeline.
// Depends on slc_pkg, slc_ifs and slc_scale10; assertions from assert_macros.svh.
//
// Converts one raw byte per cycle into milli-units, value =
// ((M*raw*1000) + B*1000*10^k1) * 10^k2, negative powers dividing with
// truncation toward zero, wrapping at 64 bits. Both input channels are held
// off while in reset and until the run flag is set after release. From then
// on a transfer is taken every cycle unless the result side holds back; the
// pipeline depth is set by the two pipelined restoring dividers (4 quotient
// bits per stage) and their split multipliers. Config writes are taken every
// cycle and must only happen with the pipeline empty.
`include "assert_macros.svh"

module sensor_reading_linear_convert (
	input  logic      clk,
	input  logic      arst_n,
	slc_req_if.sink   req,
	slc_rsp_if.source rsp,
	slc_cfg_if.sink   cfg
);
	import slc_pkg::*;

	typedef struct packed {
		logic avail;
		logic halve;
	} slc_flags_t;

	localparam int SIDE_A_W = P1000_W + $bits(slc_flags_t);
	localparam int SIDE_B_W = $bits(slc_flags_t);

	logic signed [GAIN_W-1:0] gain_m_q;
	logic signed [OFFS_W-1:0] offset_b_q;
	logic [EXP_W-1:0]         offset_exp_q;
	logic [EXP_W-1:0]         result_exp_q;
	logic                     halve_q;
	logic                     run_q;

	logic adv;

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [OFFB_W-1:0]  offb_s1, offb_s2;
	logic signed [P1000_W-1:0] p1000_s2;
	logic signed [ACC_W-1:0]   acc_s3;
	logic signed [VALUE_W-1:0] value_s4;
	slc_flags_t                flags_s1, flags_s2, flags_s3;
	logic                      avail_s4;

	logic signed [PROD_W-1:0]  gain_x, samp_x;
	logic signed [OFFB_W-1:0]  offb_x;
	logic signed [P1000_W-1:0] prod_x;
	slc_flags_t                flags_in;

	logic                      va;
	logic [OFF_W-1:0]          off_a;
	logic [SIDE_A_W-1:0]       side_a;
	logic signed [P1000_W-1:0] p1000_a;
	slc_flags_t                flags_a;

	logic                      vb;
	logic [VALUE_W-1:0]        val_b;
	slc_flags_t                flags_b;
	logic [VALUE_W-1:0]        halved;

	// run flag: set on the clock after reset is released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	// configuration
	assign cfg.ready = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_m_q     <= GAIN_W'(1);
			offset_b_q   <= '0;
			offset_exp_q <= '0;
			result_exp_q <= '0;
			halve_q      <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_GAIN_M:        gain_m_q     <= cfg.data[GAIN_W-1:0];
				REG_OFFSET_B:      offset_b_q   <= cfg.data[OFFS_W-1:0];
				REG_OFFSET_EXP:    offset_exp_q <= cfg.data[EXP_W-1:0];
				REG_RESULT_EXP:    result_exp_q <= cfg.data[EXP_W-1:0];
				REG_HALVE_READING: halve_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output register is full and held
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv && run_q;

	// stage 1: M*raw, B*1000, availability
	assign gain_x = PROD_W'(gain_m_q);
	assign samp_x = $signed(PROD_W'(req.sample));
	assign offb_x = OFFB_W'(offset_b_q);

	assign flags_in.avail = (req.mode == MODE_READING)
		|| ((req.mode == MODE_UPPER_CRIT) && req.threshold_mask[CRIT_BIT])
		|| ((req.mode == MODE_UPPER_NONCRIT) && req.threshold_mask[NONCRIT_BIT]);
	assign flags_in.halve = (req.mode == MODE_READING) && halve_q;

	// stage 2: times 1000 as 1024 - 16 - 8
	assign prod_x = P1000_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid && req.ready;
			v_s2 <= v_s1;
			v_s3 <= va;
			v_s4 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= gain_x * samp_x;
			offb_s1  <= (offb_x <<< 10) - (offb_x <<< 4) - (offb_x <<< 3);
			flags_s1 <= flags_in;
			p1000_s2 <= (prod_x <<< 10) - (prod_x <<< 4) - (prod_x <<< 3);
			offb_s2  <= offb_s1;
			flags_s2 <= flags_s1;
			acc_s3   <= ACC_W'(p1000_a) + ACC_W'($signed(off_a));
			flags_s3 <= flags_a;
			value_s4 <= flags_b.avail ? $signed(halved) : '0;
			avail_s4 <= flags_b.avail;
		end
	end

	slc_scale10 #(
		.IW (OFFB_W),
		.OW (OFF_W),
		.SW (SIDE_A_W)
	) u_off_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.x         (offb_s2),
		.side_in   ({p1000_s2, flags_s2}),
		.exp_k     (offset_exp_q),
		.out_valid (va),
		.y         (off_a),
		.side_out  (side_a)
	);

	assign {p1000_a, flags_a} = side_a;

	slc_scale10 #(
		.IW (ACC_W),
		.OW (VALUE_W),
		.SW (SIDE_B_W)
	) u_res_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.x         (acc_s3),
		.side_in   (flags_s3),
		.exp_k     (result_exp_q),
		.out_valid (vb),
		.y         (val_b),
		.side_out  (flags_b)
	);

	// arithmetic halve for readings
	assign halved = flags_b.halve ? {val_b[VALUE_W-1], val_b[VALUE_W-1:1]} : val_b;

	assign rsp.valid     = v_s4;
	assign rsp.value     = value_s4;
	assign rsp.available = avail_s4;

	`SLC_ASSERT_IMPLIES(a_na_is_zero, clk, arst_n, rsp.valid && !rsp.available, rsp.value == '0, "unavailable result carries a nonzero value")
	`SLC_ASSERT_IMPLIES(a_no_take_when_held, clk, arst_n, req.valid && req.ready, !rsp.valid || rsp.ready, "transfer taken while output held")
	`SLC_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !adv, $stable(v_s1) && $stable(v_s2) && $stable(v_s3), "pipeline valid moved during stall")
	`SLC_ASSERT_NEXT(a_take_enters_s1, clk, arst_n, req.valid && req.ready, v_s1, "transfer did not reach first stage")

endmodule
